[rtl/lru_page_replacement_list_core_defines.svh]
// Assertion helpers for the RTL of the LRU replacement list.
`ifndef LRU_PAGE_REPLACEMENT_LIST_CORE_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_LIST_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lru list check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRUP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lru list check failed");

`endif

[rtl/lrup_pkg.sv]
package lrup_pkg;

    // Field widths of the request and result.
    localparam int MODE_W   = 2;
    localparam int PAGE_W   = 20;
    localparam int PROC_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_TOUCH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EVICT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PAGE_W-1:0] page_number;
        logic [PROC_W-1:0] process_id;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic                out_valid;
        logic [PAGE_W-1:0]   out_page;
        logic [PROC_W-1:0]   out_process;
        logic [OCC_W-1:0]    occupancy;
    } t_rsp;

endpackage

[rtl/lrup_update.sv]
module lrup_update #(
    parameter int CAPACITY = 16,
    parameter int RW       = 4,
    parameter int CW       = 5
) (
    input  lrup_pkg::t_req                i_req,
    input  logic [CAPACITY-1:0]           i_vld,
    input  logic [lrup_pkg::PAGE_W-1:0]   i_page [CAPACITY],
    input  logic [lrup_pkg::PROC_W-1:0]   i_proc [CAPACITY],
    input  logic [RW-1:0]                 i_rank [CAPACITY],
    input  logic [CW-1:0]                 i_count,
    output logic [CAPACITY-1:0]           o_vld,
    output logic [RW-1:0]                 o_rank [CAPACITY],
    output logic [CW-1:0]                 o_count,
    output logic [CAPACITY-1:0]           o_ins,
    output lrup_pkg::t_rsp                o_rsp
);
    import lrup_pkg::*;

    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_last;
    logic [CAPACITY-1:0] w_last_oh;
    logic [CAPACITY-1:0] w_free_oh;
    logic [CAPACITY-1:0] w_drop_oh;
    logic [RW-1:0]       w_hit_rank;
    logic [RW-1:0]       w_drop_rank;
    logic [PAGE_W-1:0]   w_drop_page;
    logic [PROC_W-1:0]   w_drop_proc;
    logic                w_hit;
    logic                w_drop;

    // Parallel pair match and search for the least recent entry.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_match[i] = i_vld[i] && (i_page[i] == i_req.page_number)
                         && (i_proc[i] == i_req.process_id);
            w_last[i]  = i_vld[i] && (CW'(i_rank[i]) == (i_count - CW'(1)));
        end
    end

    assign w_hit     = |w_match;
    assign w_last_oh = w_last & (~w_last + CAPACITY'(1));
    // Lowest free slot: the lowest zero of the valid vector.
    assign w_free_oh = ~i_vld & (i_vld + CAPACITY'(1));
    assign w_drop_oh = (i_req.mode == MODE_REMOVE) ? w_match : w_last_oh;

    // Read out the rank and contents of the matched and dropped slots.
    always_comb begin
        w_hit_rank  = '0;
        w_drop_rank = '0;
        w_drop_page = '0;
        w_drop_proc = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit_rank  = w_hit_rank  | (w_match[i]   ? i_rank[i] : '0);
            w_drop_rank = w_drop_rank | (w_drop_oh[i] ? i_rank[i] : '0);
            w_drop_page = w_drop_page | (w_drop_oh[i] ? i_page[i] : '0);
            w_drop_proc = w_drop_proc | (w_drop_oh[i] ? i_proc[i] : '0);
        end
    end

    // Next state and result for the operation.
    always_comb begin
        o_vld   = i_vld;
        o_rank  = i_rank;
        o_count = i_count;
        o_ins   = '0;
        o_rsp   = '0;
        w_drop  = 1'b0;
        unique case (i_req.mode)
            MODE_TOUCH: begin
                if (w_hit) begin
                    // Move the pair to most recent; younger entries age by one.
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (i_vld[i] && (i_rank[i] < w_hit_rank)) begin
                            o_rank[i] = i_rank[i] + RW'(1);
                        end
                        if (w_match[i]) begin
                            o_rank[i] = '0;
                        end
                    end
                    o_rsp.hit = 1'b1;
                end else if (i_count >= CW'(CAPACITY)) begin
                    o_rsp.status = ST_FULL;
                end else begin
                    // Insert at most recent; every held entry ages by one.
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (i_vld[i]) begin
                            o_rank[i] = i_rank[i] + RW'(1);
                        end
                        if (w_free_oh[i]) begin
                            o_vld[i]  = 1'b1;
                            o_rank[i] = '0;
                        end
                    end
                    o_ins   = w_free_oh;
                    o_count = i_count + CW'(1);
                end
            end
            MODE_EVICT: begin
                if ((i_count == '0) || !(|w_last_oh)) begin
                    o_rsp.status = ST_EMPTY;
                end else begin
                    w_drop = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (w_hit) begin
                    w_drop = 1'b1;
                end else begin
                    o_rsp.status = ST_MISSING;
                end
            end
            default: begin
            end
        endcase

        // Take out the selected entry and close the gap in the ranks.
        if (w_drop) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (i_vld[i] && (i_rank[i] > w_drop_rank)) begin
                    o_rank[i] = i_rank[i] - RW'(1);
                end
                if (w_drop_oh[i]) begin
                    o_vld[i]  = 1'b0;
                    o_rank[i] = '0;
                end
            end
            o_count           = i_count - CW'(1);
            o_rsp.out_valid   = 1'b1;
            o_rsp.out_page    = w_drop_page;
            o_rsp.out_process = w_drop_proc;
        end
        o_rsp.occupancy = OCC_W'(o_count);
    end

endmodule

[rtl/lru_page_replacement_list_core.sv]
// LRU replacement list of (page, process) pairs, CAPACITY entries.
// Request channel: i_req_valid / o_req_stall carry i_req (mode, page, process).
// Mode touch looks a pair up and makes it most recent, inserting it on a miss
// when not full; evict drops the least recent entry, remove a named pair.
// Result channel: o_rsp_valid / i_rsp_stall carry o_rsp, one result per request.
// A request lands in an input register; once the result register is free
// or drains, the parallel match over all entries and the rank update run
// and load the result register. One request is taken every cycle while
// the receiver does not stall, as the match and rank update of the entry
// table are combinational.
// When the receiver stalls, the result is held; the input register still
// takes one more request, and the sender is stalled once both are full.
// Reset (i_rst_n low at a clock edge) empties the list and both stages.
`include "lru_page_replacement_list_core_defines.svh"

module lru_page_replacement_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  lrup_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output lrup_pkg::t_rsp  o_rsp
);
    import lrup_pkg::*;

    localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Request and result stages.
    t_req                r_req;
    logic                r_req_vld;
    t_rsp                r_rsp;
    logic                r_rsp_vld;

    // Entry table.
    logic [CAPACITY-1:0] r_vld;
    logic [PAGE_W-1:0]   r_page [CAPACITY];
    logic [PROC_W-1:0]   r_proc [CAPACITY];
    logic [RW-1:0]       r_rank [CAPACITY];
    logic [CW-1:0]       r_count;

    logic [CAPACITY-1:0] n_vld;
    logic [RW-1:0]       n_rank [CAPACITY];
    logic [CW-1:0]       n_count;
    logic [CAPACITY-1:0] w_ins;
    t_rsp                n_rsp;
    logic                w_adv;
    logic                w_acc;
    logic                w_mru_seen;

    // A request moves on when the result register is free or drains now.
    assign w_adv       = r_req_vld && (!r_rsp_vld || !i_rsp_stall);
    assign o_req_stall = r_req_vld && !w_adv;
    assign w_acc       = i_req_valid && !o_req_stall;
    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

    lrup_update #(
        .CAPACITY (CAPACITY),
        .RW       (RW),
        .CW       (CW)
    ) u_update (
        .i_req   (r_req),
        .i_vld   (r_vld),
        .i_page  (r_page),
        .i_proc  (r_proc),
        .i_rank  (r_rank),
        .i_count (r_count),
        .o_vld   (n_vld),
        .o_rank  (n_rank),
        .o_count (n_count),
        .o_ins   (w_ins),
        .o_rsp   (n_rsp)
    );

    // Stage control and entry state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
            r_vld     <= '0;
            r_count   <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (w_acc) begin
                r_req_vld <= 1'b1;
            end else if (w_adv) begin
                r_req_vld <= 1'b0;
            end
            if (w_adv) begin
                r_rsp_vld <= 1'b1;
                r_vld     <= n_vld;
                r_rank    <= n_rank;
                r_count   <= n_count;
            end else if (!i_rsp_stall) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req <= i_req;
        end
        if (w_adv) begin
            r_rsp <= n_rsp;
            for (int i = 0; i < CAPACITY; i++) begin
                if (w_ins[i]) begin
                    r_page[i] <= r_req.page_number;
                    r_proc[i] <= r_req.process_id;
                end
            end
        end
    end

    // Some held entry carries the most recent rank.
    always_comb begin
        w_mru_seen = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_mru_seen = w_mru_seen | (r_vld[i] && (r_rank[i] == '0));
        end
    end

    // The count always equals the number of held entries.
    `LRUP_ASSERT_SAME(a_count_matches, i_clk, i_rst_n, 1'b1, $countones(r_vld) == r_count)
    // A non-empty list always holds a most recent entry.
    `LRUP_ASSERT_SAME(a_mru_present, i_clk, i_rst_n, r_count != '0, w_mru_seen)
    // The reported occupancy follows the count left by the operation.
    `LRUP_ASSERT_NEXT(a_occupancy, i_clk, i_rst_n, w_adv, r_rsp.occupancy == OCC_W'(r_count))

endmodule
